// ===== src/mpwd_pkg.sv =====
`default_nettype none
package mpwd_pkg;

    // Timer and field widths
    localparam int unsigned TIMER_PERIOD = 60000;
    localparam int unsigned EDGE_W       = 16;
    localparam int unsigned SHORT_W      = 12;
    localparam int unsigned TOL_W        = 10;
    localparam int unsigned NOM_W        = SHORT_W + 1;
    localparam int unsigned DIFF_W       = EDGE_W + 2;

    // Register reset values
    localparam logic [SHORT_W-1:0] SHORT_RESET = SHORT_W'(500);
    localparam logic [TOL_W-1:0]   TOL_RESET   = TOL_W'(150);
    localparam logic [EDGE_W-1:0]  MAX_RESET   = EDGE_W'(4000);
    localparam logic [EDGE_W-1:0]  MIN_RESET   = EDGE_W'(100);

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SHORT_WIDTH = 2'd0,
        REG_TOLERANCE   = 2'd1,
        REG_MAX_WIDTH   = 2'd2,
        REG_MIN_WIDTH   = 2'd3
    } t_cfg_reg;

    typedef struct packed {
        logic [SHORT_W-1:0] short_width;
        logic [TOL_W-1:0]   tolerance;
        logic [EDGE_W-1:0]  max_width;
        logic [EDGE_W-1:0]  min_width;
    } t_cfg;

    // Decoded bits of one item, in emission order from bit 0
    localparam int unsigned MAX_BITS = 3;
    localparam int unsigned CNT_W    = 2;
    typedef struct packed {
        logic [CNT_W-1:0]    count;
        logic [MAX_BITS-1:0] bits;
    } t_packet;

    // Queue between classifier and serializer
    localparam int unsigned Q_DEPTH = 4;
    localparam int unsigned Q_AW    = $clog2(Q_DEPTH);
    localparam int unsigned Q_CW    = $clog2(Q_DEPTH + 1);

    // Difference modulo the timer period, clamped at zero
    function automatic logic [EDGE_W-1:0] wrap_diff(input logic [EDGE_W-1:0] earlier,
                                                    input logic [EDGE_W-1:0] later);
        logic signed [DIFF_W-1:0] d;
        d = signed'({2'b00, later}) - signed'({2'b00, earlier});
        if (d < 0) d = d + signed'(DIFF_W'(TIMER_PERIOD));
        if (d < 0) d = '0;
        return d[EDGE_W-1:0];
    endfunction

    // Value within tolerance of a nominal width
    function automatic logic near(input logic [EDGE_W-1:0] v,
                                  input logic [NOM_W-1:0]  nom,
                                  input logic [TOL_W-1:0]  tol);
        logic signed [DIFF_W-1:0] vs;
        logic signed [DIFF_W-1:0] hi;
        logic signed [DIFF_W-1:0] lo;
        vs = signed'({2'b00, v});
        hi = signed'(DIFF_W'(nom)) + signed'(DIFF_W'(tol));
        lo = signed'(DIFF_W'(nom)) - signed'(DIFF_W'(tol));
        return (vs <= hi) && (vs >= lo);
    endfunction

endpackage
`default_nettype wire

// ===== src/mpwd_front.sv =====
`default_nettype none
module mpwd_front (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire mpwd_pkg::t_cfg             i_cfg,
    input  wire logic                       i_valid,
    output logic                            o_stall,
    input  wire logic [mpwd_pkg::EDGE_W-1:0] i_first_edge,
    input  wire logic [mpwd_pkg::EDGE_W-1:0] i_second_edge,
    input  wire logic                       i_start_of_frame,
    output logic                            o_push,
    output mpwd_pkg::t_packet               o_packet,
    input  wire logic                       i_full
);
    import mpwd_pkg::*;

    logic              r_a_valid;
    logic [EDGE_W-1:0] r_a_width;
    logic [EDGE_W-1:0] r_a_gap;
    logic              r_a_sof;
    logic [EDGE_W-1:0] r_prev_edge;
    logic              r_seen;
    logic              r_last;
    logic              n_seen;
    logic              n_last;

    logic              accept;
    logic              advance;
    logic              drop;
    logic [EDGE_W-1:0] prev_eff;
    logic [NOM_W-1:0]  nom_s;
    logic [NOM_W-1:0]  nom_l;
    logic              w_s, w_l, g_s, g_l;
    t_packet           pkt;

    assign accept   = i_valid && !o_stall;
    assign prev_eff = i_start_of_frame ? '0 : r_prev_edge;

    // Track the previous pulse end and the stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_prev_edge <= '0;
            r_seen      <= 1'b0;
            r_last      <= 1'b0;
        end else begin
            if (accept) begin
                r_a_valid   <= 1'b1;
                r_prev_edge <= i_second_edge;
            end else if (advance) begin
                r_a_valid <= 1'b0;
            end
            if (advance) begin
                r_seen <= n_seen;
                r_last <= n_last;
            end
        end
    end

    // Capture width and gap of the accepted item
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_width <= wrap_diff(i_first_edge, i_second_edge);
            r_a_gap   <= wrap_diff(prev_eff, i_first_edge);
            r_a_sof   <= i_start_of_frame;
        end
    end

    // Classify against short and long windows
    assign nom_s = {1'b0, i_cfg.short_width};
    assign nom_l = {i_cfg.short_width, 1'b0};
    assign w_s   = near(r_a_width, nom_s, i_cfg.tolerance);
    assign w_l   = near(r_a_width, nom_l, i_cfg.tolerance);
    assign g_s   = near(r_a_gap, nom_s, i_cfg.tolerance);
    assign g_l   = near(r_a_gap, nom_l, i_cfg.tolerance);
    assign drop  = (r_a_width > i_cfg.max_width) || (r_a_width < i_cfg.min_width);

    // Build the bit sequence and the state that follows it
    always_comb begin
        logic seen;
        logic lb;
        logic b;
        logic [CNT_W-1:0] n;
        seen = r_a_sof ? 1'b0 : r_seen;
        lb   = r_a_sof ? 1'b0 : r_last;
        n    = '0;
        pkt  = '0;
        b    = 1'b0;
        if (!drop) begin
            if (w_s) begin
                priority if (!seen) begin
                    seen = 1'b1;
                    b    = 1'b0;
                end else if (g_s) begin
                    b = lb;
                end else if (g_l) begin
                    b = !lb;
                end else begin
                    b = 1'b0;
                end
                pkt.bits[n] = b;
                lb          = b;
                n           = n + CNT_W'(1);
            end
            if (w_l) begin
                priority if (g_s) begin
                    pkt.bits[n]              = lb;
                    pkt.bits[n + CNT_W'(1)]  = !lb;
                    lb                       = !lb;
                    n                        = n + CNT_W'(2);
                end else if (g_l) begin
                    pkt.bits[n]              = !lb;
                    pkt.bits[n + CNT_W'(1)]  = lb;
                    n                        = n + CNT_W'(2);
                end else begin
                    n = n;
                end
            end
        end
        pkt.count = n;
        n_seen    = seen;
        n_last    = lb;
    end

    // Retire the stage unless a nonempty packet meets a full queue
    assign advance  = r_a_valid && ((pkt.count == '0) || !i_full);
    assign o_stall  = r_a_valid && !advance;
    assign o_push   = advance && (pkt.count != '0);
    assign o_packet = pkt;

    a_push_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> !i_full) else $error("push into full queue");
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |=> r_a_valid) else $error("stalled stage lost its item");
    a_drop_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_valid && drop) |-> !o_push) else $error("dropped pulse produced bits");

endmodule
`default_nettype wire

// ===== src/mpwd_queue.sv =====
`default_nettype none
module mpwd_queue (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire mpwd_pkg::t_packet i_packet,
    output logic                   o_full,
    input  wire logic              i_pop,
    output mpwd_pkg::t_packet      o_head,
    output logic                   o_empty
);
    import mpwd_pkg::*;

    t_packet         r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr;
    logic [Q_AW-1:0] r_rd;
    logic [Q_CW-1:0] r_count;

    assign o_full  = (r_count == Q_CW'(Q_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd];

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wr <= (r_wr == Q_AW'(Q_DEPTH - 1)) ? '0 : r_wr + Q_AW'(1);
            if (i_pop)  r_rd <= (r_rd == Q_AW'(Q_DEPTH - 1)) ? '0 : r_rd + Q_AW'(1);
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + Q_CW'(1);
                2'b01:   r_count <= r_count - Q_CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    // Store entries
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_packet;
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= Q_CW'(Q_DEPTH)) else $error("queue over capacity");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty) else $error("pop from empty queue");
    a_entry_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty |-> (o_head.count != '0)) else $error("queued packet without bits");

endmodule
`default_nettype wire

// ===== src/mpwd_back.sv =====
`default_nettype none
module mpwd_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire mpwd_pkg::t_packet i_head,
    input  wire logic              i_empty,
    output logic                   o_pop,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output logic                   o_bit_value,
    output logic                   o_last_in_run
);
    import mpwd_pkg::*;

    logic             r_o_valid;
    logic             r_o_bit;
    logic             r_o_last;
    logic [CNT_W-1:0] r_idx;
    logic             load;
    logic             is_last;

    // Load the output register whenever it is free and the queue is not empty
    assign load    = !i_empty && (!r_o_valid || !i_stall);
    assign is_last = (r_idx == i_head.count - CNT_W'(1));
    assign o_pop   = load && is_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
            r_idx     <= '0;
        end else begin
            if (load) begin
                r_o_valid <= 1'b1;
                r_idx     <= is_last ? '0 : r_idx + CNT_W'(1);
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Hold the payload of the item on offer
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_o_bit  <= i_head.bits[r_idx];
            r_o_last <= is_last;
        end
    end

    assign o_valid       = r_o_valid;
    assign o_bit_value   = r_o_bit;
    assign o_last_in_run = r_o_last;

    a_run_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && !i_stall && !r_o_last) |=> r_o_valid)
        else $error("gap inside a run of bits");
    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_empty |-> (r_idx < i_head.count)) else $error("bit index beyond packet");
    a_idx_rest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_idx == '0)) else $error("index not rewound after pop");

endmodule
`default_nettype wire

// ===== src/manchester_pulse_width_decoder_top.sv =====
`default_nettype none
// Channel   Valid     Stall     Payload
// input     i_valid   o_stall   i_first_edge, i_second_edge, i_start_of_frame
// output    o_valid   i_stall   o_bit_value, o_last_in_run
// config    i_cfg_we  -         i_cfg_index, i_cfg_data
//
// An item yields one to three decoded bits at the output, or none; the
// serializer gives out one bit a cycle while i_stall is low. The first bit
// passes the classifier stage register, the queue and the output register.
// A four-entry queue sits between classifier and serializer, so o_stall rises
// only when the queue is full and the classified item has bits to store.
// Synchronous active-low reset clears state and loads register defaults.
module manchester_pulse_width_decoder_top (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [mpwd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [mpwd_pkg::EDGE_W-1:0]    i_cfg_data,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic [mpwd_pkg::EDGE_W-1:0]    i_first_edge,
    input  wire logic [mpwd_pkg::EDGE_W-1:0]    i_second_edge,
    input  wire logic                          i_start_of_frame,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic                               o_bit_value,
    output logic                               o_last_in_run
);
    import mpwd_pkg::*;

    t_cfg    r_cfg;
    logic    push;
    logic    pop;
    logic    full;
    logic    empty;
    t_packet push_pkt;
    t_packet head_pkt;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.short_width <= SHORT_RESET;
            r_cfg.tolerance   <= TOL_RESET;
            r_cfg.max_width   <= MAX_RESET;
            r_cfg.min_width   <= MIN_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_index))
                REG_SHORT_WIDTH: r_cfg.short_width <= i_cfg_data[SHORT_W-1:0];
                REG_TOLERANCE:   r_cfg.tolerance   <= i_cfg_data[TOL_W-1:0];
                REG_MAX_WIDTH:   r_cfg.max_width   <= i_cfg_data;
                REG_MIN_WIDTH:   r_cfg.min_width   <= i_cfg_data;
                default:         r_cfg             <= r_cfg;
            endcase
        end
    end

    mpwd_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (r_cfg),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_first_edge     (i_first_edge),
        .i_second_edge    (i_second_edge),
        .i_start_of_frame (i_start_of_frame),
        .o_push           (push),
        .o_packet         (push_pkt),
        .i_full           (full)
    );

    mpwd_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_packet (push_pkt),
        .o_full   (full),
        .i_pop    (pop),
        .o_head   (head_pkt),
        .o_empty  (empty)
    );

    mpwd_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (head_pkt),
        .i_empty       (empty),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_bit_value   (o_bit_value),
        .o_last_in_run (o_last_in_run)
    );

endmodule
`default_nettype wire
